[hdl/pra_pkg.sv]
// shared types and constants for the page range allocator
`timescale 1ns / 1ps

package pra_pkg;

    // fixed widths of the transaction fields and the config port
    localparam int FIELD_W   = 48;
    localparam int CMD_W     = 2;
    localparam int ALOG_W    = 6;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BEGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_END   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_ALLOC_AT = 2'd1,
        CMD_FREE     = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_OVERLAP   = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_BAD       = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    // datapath commands issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CALC,
        OP_INIT,
        OP_READ,
        OP_EVAL,
        OP_EVAL_END,
        OP_DECIDE,
        OP_WRITE,
        OP_RM_INIT,
        OP_RM_READ,
        OP_RM_WRITE,
        OP_RM_DONE,
        OP_IN_INIT,
        OP_IN_READ,
        OP_IN_WRITE,
        OP_IN_DONE,
        OP_FINISH
    } dp_op_t;

    // datapath status back to the controller
    typedef struct packed {
        logic pre_ok;
        logic at_end;
        logic stop;
        logic act_wr;
        logic act_rm;
        logic act_in;
        logic rm_more;
        logic in_more;
        logic out_free;
    } dp_stat_t;

endpackage

[hdl/pra_req_if.sv]
// request channel interface
`timescale 1ns / 1ps

interface pra_req_if;
    import pra_pkg::*;

    logic                valid;
    logic                ready;
    cmd_t                cmd;
    logic [FIELD_W-1:0]  request_begin;
    logic [FIELD_W-1:0]  request_length;
    logic [ALOG_W-1:0]   alignment_log2;

    modport source (output valid, cmd, request_begin, request_length, alignment_log2,
                    input ready);
    modport sink   (input valid, cmd, request_begin, request_length, alignment_log2,
                    output ready);
endinterface

[hdl/pra_rsp_if.sv]
// response channel interface
`timescale 1ns / 1ps

interface pra_rsp_if;
    import pra_pkg::*;

    logic                valid;
    logic                ready;
    logic [FIELD_W-1:0]  result_begin;
    logic [FIELD_W-1:0]  result_length;
    status_t             status;
    logic                hit;

    modport source (output valid, result_begin, result_length, status, hit,
                    input ready);
    modport sink   (input valid, result_begin, result_length, status, hit,
                    output ready);
endinterface

[hdl/page_range_allocator.sv]
// top level of the page range allocator
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    cmd, request_begin, request_length, alignment_log2
//  rsp      out  valid/ready    result_begin, result_length, status, hit
//  cfg      in   cfg_we         cfg_index, cfg_data (base_begin, base_end)
//
// a transaction scans the table one entry at a time, a read state then an evaluate
// state per entry, with one more evaluation when the scan runs to the table end, and
// when the table shifts each moved entry is checked, read and then written back.
// reset empties the table and zeroes the window; a config write also empties it.
// the response register lets a finished result wait while the next request is
// taken; a stalled response only holds the block at the end of the next request.
`timescale 1ns / 1ps

module page_range_allocator #(
    parameter int MAX_RANGES = 64,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pra_pkg::FIELD_W-1:0]   cfg_data,
    pra_req_if.sink                       req,
    pra_rsp_if.source                     rsp
);
    import pra_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;
    logic     ready;

    assign req.ready = ready;

    // sequencer
    pra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .stat      (stat),
        .op        (op)
    );

    // table and arithmetic
    pra_datapath #(
        .MAX_RANGES (MAX_RANGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (req.cmd),
        .in_begin  (req.request_begin),
        .in_length (req.request_length),
        .in_alog   (req.alignment_log2),
        .op        (op),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule

[hdl/pra_ctrl.sv]
// sequencing state machine of the page range allocator
`timescale 1ns / 1ps

module pra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pra_pkg::dp_stat_t stat,
    output pra_pkg::dp_op_t   op
);
    import pra_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CALC,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_END,
        S_DECIDE,
        S_WRITE,
        S_RM_INIT,
        S_RM_CHK,
        S_RM_RD,
        S_RM_WR,
        S_RM_DONE,
        S_IN_INIT,
        S_IN_CHK,
        S_IN_RD,
        S_IN_WR,
        S_IN_DONE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   accept;

    assign req_ready = ready_reg;
    assign accept    = req_valid && ready_reg;

    // command decode and next state
    always_comb
    begin
        op         = OP_NONE;
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op         = OP_LOAD;
                    state_next = S_CALC;
                    ready_next = 1'b0;
                end
            end
            S_CALC:
            begin
                op         = OP_CALC;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                op         = OP_INIT;
                state_next = stat.pre_ok ? S_SCAN_RD : S_DECIDE;
            end
            S_SCAN_RD:
            begin
                if (stat.at_end)
                begin
                    state_next = S_END;
                end
                else
                begin
                    op         = OP_READ;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                op         = OP_EVAL;
                state_next = stat.stop ? S_DECIDE : S_SCAN_RD;
            end
            S_END:
            begin
                op         = OP_EVAL_END;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                op         = OP_DECIDE;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                op = stat.act_wr ? OP_WRITE : OP_NONE;
                if (stat.act_rm)
                    state_next = S_RM_INIT;
                else if (stat.act_in)
                    state_next = S_IN_INIT;
                else
                    state_next = S_FINISH;
            end
            S_RM_INIT:
            begin
                op         = OP_RM_INIT;
                state_next = S_RM_CHK;
            end
            S_RM_CHK:
            begin
                state_next = stat.rm_more ? S_RM_RD : S_RM_DONE;
            end
            S_RM_RD:
            begin
                op         = OP_RM_READ;
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                op         = OP_RM_WRITE;
                state_next = S_RM_CHK;
            end
            S_RM_DONE:
            begin
                op         = OP_RM_DONE;
                state_next = S_FINISH;
            end
            S_IN_INIT:
            begin
                op         = OP_IN_INIT;
                state_next = S_IN_CHK;
            end
            S_IN_CHK:
            begin
                state_next = stat.in_more ? S_IN_RD : S_IN_DONE;
            end
            S_IN_RD:
            begin
                op         = OP_IN_READ;
                state_next = S_IN_WR;
            end
            S_IN_WR:
            begin
                op         = OP_IN_WRITE;
                state_next = S_IN_CHK;
            end
            S_IN_DONE:
            begin
                op         = OP_IN_DONE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    op         = OP_FINISH;
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

[hdl/pra_datapath.sv]
// range table memory, scan registers and result register
`timescale 1ns / 1ps

module pra_datapath #(
    parameter int MAX_RANGES = 64,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pra_pkg::FIELD_W-1:0]   cfg_data,
    input  pra_pkg::cmd_t                 in_cmd,
    input  logic [pra_pkg::FIELD_W-1:0]   in_begin,
    input  logic [pra_pkg::FIELD_W-1:0]   in_length,
    input  logic [pra_pkg::ALOG_W-1:0]    in_alog,
    input  pra_pkg::dp_op_t               op,
    output pra_pkg::dp_stat_t             stat,
    pra_rsp_if.source                     rsp
);
    import pra_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int DW = 2 * AW;
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int XW = ((AW > PAGE_SHIFT) ? AW : PAGE_SHIFT) + 1;
    localparam logic [XW-1:0] PG_M1 = XW'((65'd1 << PAGE_SHIFT) - 65'd1);

    function automatic logic fits_aw(input logic [XW-1:0] v);
        return (v >> AW) == '0;
    endfunction

    // range table: start in the upper half, end in the lower half
    logic [DW-1:0] mem [MAX_RANGES];
    logic [DW-1:0] rdata_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    // control state
    logic [AW-1:0] base_begin_reg;
    logic [AW-1:0] base_end_reg;
    logic [CW-1:0] count_reg;
    logic          res_valid_reg;

    // request and derived values
    cmd_t          cmd_reg;
    logic [AW-1:0] rb_reg;
    logic [AW-1:0] rl_reg;
    logic [ALOG_W-1:0] alog_reg;
    logic [AW-1:0] len_reg;
    logic [AW-1:0] re_reg;
    logic [AW-1:0] b_reg;
    logic [AW-1:0] e_reg;
    logic [XW-1:0] al_m1_reg;
    status_t       pre_st_reg;
    logic          qin_reg;

    // scan state
    logic [CW-1:0] idx_reg;
    logic          prev_valid_reg;
    logic [AW-1:0] prev_start_reg;
    logic [AW-1:0] prev_end_reg;
    logic          cap_reg;
    logic [CW-1:0] pos_reg;
    logic          cur_valid_reg;
    logic [AW-1:0] cur_start_reg;
    logic [AW-1:0] cur_end_reg;
    logic          ovl_reg;
    logic          hit_reg;
    logic [AW-1:0] gb_reg;

    // table update plan
    logic          act_wr_reg;
    logic          act_rm_reg;
    logic          act_in_reg;
    logic [IW-1:0] act_wa_reg;
    logic [DW-1:0] act_wd_reg;
    logic [CW-1:0] ins_pos_reg;
    logic [DW-1:0] ins_data_reg;
    status_t       fin_st_reg;
    logic [AW-1:0] fin_b_reg;
    logic [AW-1:0] fin_l_reg;
    logic          fin_hit_reg;

    // result register
    logic [AW-1:0] res_b_reg;
    logic [AW-1:0] res_l_reg;
    status_t       res_st_reg;
    logic          res_hit_reg;

    // request prechecks
    logic [XW-1:0] rbx;
    logic [XW-1:0] len_sum;
    logic [XW-1:0] re_sum;
    logic [AW-1:0] re_v;
    logic [AW-1:0] re_m1;
    logic [XW-1:0] e_sum;
    logic [ALOG_W-1:0] alog_eff;
    logic [XW-1:0] al_m1;
    logic          rb_in;
    logic          rem1_in;
    status_t       pre_st;

    always_comb
    begin
        rbx      = XW'(rb_reg);
        len_sum  = XW'(rl_reg) + PG_M1;
        re_sum   = rbx + XW'(rl_reg);
        re_v     = re_sum[AW-1:0];
        re_m1    = re_v - AW'(1);
        e_sum    = XW'(re_v) + PG_M1;
        alog_eff = (alog_reg < PAGE_SHIFT) ? ALOG_W'(PAGE_SHIFT) : alog_reg;
        al_m1    = (XW'(1) << alog_eff) - XW'(1);
        rb_in    = (rb_reg >= base_begin_reg) && (rb_reg < base_end_reg);
        rem1_in  = (re_m1 >= base_begin_reg) && (re_m1 < base_end_reg);
        pre_st   = ST_OK;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                if (rl_reg == '0 || alog_reg >= AW || !fits_aw(len_sum))
                    pre_st = ST_BAD;
            end
            CMD_ALLOC_AT, CMD_FREE:
            begin
                if (rl_reg == '0)
                    pre_st = ST_BAD;
                else if (!fits_aw(re_sum) || !rb_in || !rem1_in)
                    pre_st = ST_OUTSIDE;
                else if (cmd_reg == CMD_ALLOC_AT && !fits_aw(e_sum))
                    pre_st = ST_OUTSIDE;
            end
            default:
            begin
                pre_st = ST_OK;
            end
        endcase
    end

    // per-entry scan evaluation
    logic [AW-1:0] es;
    logic [AW-1:0] ee;
    logic [AW-1:0] g;
    logic [AW-1:0] ge;
    logic [XW-1:0] a_sum;
    logic [AW-1:0] a_v;
    logic          fit;
    logic          m_ovl;
    logic          m_ge;
    logic          m_free;
    logic          m_hit;

    always_comb
    begin
        es     = rdata_reg[DW-1:AW];
        ee     = rdata_reg[AW-1:0];
        g      = prev_valid_reg ? prev_end_reg : base_begin_reg;
        ge     = (op == OP_EVAL_END) ? base_end_reg : es;
        a_sum  = XW'(g) + al_m1_reg;
        a_v    = a_sum[AW-1:0] & ~al_m1_reg[AW-1:0];
        fit    = (g < ge) && fits_aw(a_sum) && (a_v < ge) && ((ge - a_v) >= len_reg);
        m_ovl  = (es < e_reg) && (ee > b_reg);
        m_ge   = es >= b_reg;
        m_free = (es <= rb_reg) && (re_reg <= ee);
        m_hit  = (es <= rb_reg) && (rb_reg < ee);
    end

    // decision on the captured neighbors
    logic [AW-1:0] e0;
    logic [AW-1:0] pb;
    logic [AW-1:0] pe;
    logic          bm;
    logic          am;
    logic          full;
    logic [CW-1:0] pos_m1;
    logic [CW-1:0] pos_p1;
    logic          left_part;
    logic          right_part;
    status_t       d_st;
    logic          d_wr;
    logic          d_rm;
    logic          d_in;
    logic [IW-1:0] d_wa;
    logic [DW-1:0] d_wd;
    logic [CW-1:0] d_ip;
    logic [DW-1:0] d_id;
    logic [AW-1:0] d_fb;
    logic [AW-1:0] d_fl;
    logic          d_hit;

    always_comb
    begin
        e0         = gb_reg + len_reg;
        pb         = (cmd_reg == CMD_ALLOC) ? gb_reg : b_reg;
        pe         = (cmd_reg == CMD_ALLOC) ? e0 : e_reg;
        bm         = prev_valid_reg && (prev_end_reg == pb);
        am         = cur_valid_reg && (cur_start_reg == pe);
        full       = count_reg >= CW'(MAX_RANGES);
        pos_m1     = pos_reg - CW'(1);
        pos_p1     = pos_reg + CW'(1);
        left_part  = cur_start_reg < rb_reg;
        right_part = re_reg < cur_end_reg;
        d_st       = ST_OK;
        d_wr       = 1'b0;
        d_rm       = 1'b0;
        d_in       = 1'b0;
        d_wa       = pos_reg[IW-1:0];
        d_wd       = {pb, pe};
        d_ip       = pos_reg;
        d_id       = {pb, pe};
        d_fb       = '0;
        d_fl       = '0;
        d_hit      = 1'b0;
        if (pre_st_reg != ST_OK)
        begin
            d_st = pre_st_reg;
        end
        else
        begin
            case (cmd_reg)
                CMD_ALLOC, CMD_ALLOC_AT:
                begin
                    if (cmd_reg == CMD_ALLOC && !cap_reg)
                        d_st = ST_NO_SPACE;
                    else if (cmd_reg == CMD_ALLOC_AT && ovl_reg)
                        d_st = ST_OVERLAP;
                    else
                    begin
                        d_fb = pb;
                        d_fl = pe - pb;
                        if (bm && am)
                        begin
                            // bridge the gap: grow the lower range, drop the upper
                            d_wr = 1'b1;
                            d_wa = pos_m1[IW-1:0];
                            d_wd = {prev_start_reg, cur_end_reg};
                            d_rm = 1'b1;
                        end
                        else if (bm)
                        begin
                            d_wr = 1'b1;
                            d_wa = pos_m1[IW-1:0];
                            d_wd = {prev_start_reg, pe};
                        end
                        else if (am)
                        begin
                            d_wr = 1'b1;
                            d_wd = {pb, cur_end_reg};
                        end
                        else if (full)
                            d_st = ST_FULL;
                        else
                            d_in = 1'b1;
                    end
                end
                CMD_FREE:
                begin
                    if (!cap_reg)
                        d_st = ST_NOT_FOUND;
                    else
                    begin
                        d_fb = rb_reg;
                        d_fl = rl_reg;
                        if (left_part && right_part)
                        begin
                            if (full)
                                d_st = ST_FULL;
                            else
                            begin
                                d_wr = 1'b1;
                                d_wd = {cur_start_reg, rb_reg};
                                d_in = 1'b1;
                                d_ip = pos_p1;
                                d_id = {re_reg, cur_end_reg};
                            end
                        end
                        else if (left_part)
                        begin
                            d_wr = 1'b1;
                            d_wd = {cur_start_reg, rb_reg};
                        end
                        else if (right_part)
                        begin
                            d_wr = 1'b1;
                            d_wd = {re_reg, cur_end_reg};
                        end
                        else
                            d_rm = 1'b1;
                    end
                end
                default:
                begin
                    d_hit = hit_reg && qin_reg;
                end
            endcase
        end
        if (d_st != ST_OK)
        begin
            d_wr  = 1'b0;
            d_rm  = 1'b0;
            d_in  = 1'b0;
            d_fb  = '0;
            d_fl  = '0;
            d_hit = 1'b0;
        end
    end

    // memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = rdata_reg;
        case (op)
            OP_READ:
            begin
                rd_en = 1'b1;
            end
            OP_RM_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(idx_reg + CW'(1));
            end
            OP_IN_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(idx_reg - CW'(1));
            end
            OP_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = act_wa_reg;
                wr_data = act_wd_reg;
            end
            OP_RM_WRITE, OP_IN_WRITE:
            begin
                wr_en = 1'b1;
            end
            OP_IN_DONE:
            begin
                wr_en   = 1'b1;
                wr_addr = ins_pos_reg[IW-1:0];
                wr_data = ins_data_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // base window, entry count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_begin_reg <= '0;
            base_end_reg   <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BASE_BEGIN)
                    base_begin_reg <= AW'(cfg_data);
                else
                    base_end_reg <= AW'(cfg_data);
                count_reg <= '0;
            end
            else if (op == OP_RM_DONE)
                count_reg <= count_reg - CW'(1);
            else if (op == OP_IN_DONE)
                count_reg <= count_reg + CW'(1);
            if (op == OP_FINISH)
                res_valid_reg <= 1'b1;
            else if (rsp.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // request, scan and plan registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg  <= in_cmd;
                rb_reg   <= AW'(in_begin);
                rl_reg   <= AW'(in_length);
                alog_reg <= in_alog;
            end
            OP_CALC:
            begin
                len_reg    <= len_sum[AW-1:0] & ~PG_M1[AW-1:0];
                re_reg     <= re_v;
                e_reg      <= e_sum[AW-1:0] & ~PG_M1[AW-1:0];
                b_reg      <= rb_reg & ~PG_M1[AW-1:0];
                al_m1_reg  <= al_m1;
                pre_st_reg <= pre_st;
                qin_reg    <= rb_in;
            end
            OP_INIT:
            begin
                idx_reg        <= '0;
                prev_valid_reg <= 1'b0;
                cap_reg        <= 1'b0;
                pos_reg        <= count_reg;
                cur_valid_reg  <= 1'b0;
                ovl_reg        <= 1'b0;
                hit_reg        <= 1'b0;
            end
            OP_EVAL:
            begin
                idx_reg <= idx_reg + CW'(1);
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (fit)
                        begin
                            cap_reg       <= 1'b1;
                            pos_reg       <= idx_reg;
                            gb_reg        <= a_v;
                            cur_valid_reg <= 1'b1;
                            cur_start_reg <= es;
                            cur_end_reg   <= ee;
                        end
                        else
                        begin
                            prev_valid_reg <= 1'b1;
                            prev_start_reg <= es;
                            prev_end_reg   <= ee;
                        end
                    end
                    CMD_ALLOC_AT:
                    begin
                        ovl_reg <= ovl_reg | m_ovl;
                        if (!cap_reg && m_ge)
                        begin
                            cap_reg       <= 1'b1;
                            pos_reg       <= idx_reg;
                            cur_valid_reg <= 1'b1;
                            cur_start_reg <= es;
                            cur_end_reg   <= ee;
                        end
                        else if (!cap_reg)
                        begin
                            prev_valid_reg <= 1'b1;
                            prev_start_reg <= es;
                            prev_end_reg   <= ee;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (m_free)
                        begin
                            cap_reg       <= 1'b1;
                            pos_reg       <= idx_reg;
                            cur_start_reg <= es;
                            cur_end_reg   <= ee;
                        end
                    end
                    default:
                    begin
                        hit_reg <= hit_reg | m_hit;
                    end
                endcase
            end
            OP_EVAL_END:
            begin
                // gap between the last range and the window end
                if (cmd_reg == CMD_ALLOC && fit)
                begin
                    cap_reg       <= 1'b1;
                    pos_reg       <= idx_reg;
                    gb_reg        <= a_v;
                    cur_valid_reg <= 1'b0;
                end
            end
            OP_DECIDE:
            begin
                act_wr_reg   <= d_wr;
                act_rm_reg   <= d_rm;
                act_in_reg   <= d_in;
                act_wa_reg   <= d_wa;
                act_wd_reg   <= d_wd;
                ins_pos_reg  <= d_ip;
                ins_data_reg <= d_id;
                fin_st_reg   <= d_st;
                fin_b_reg    <= d_fb;
                fin_l_reg    <= d_fl;
                fin_hit_reg  <= d_hit;
            end
            OP_RM_INIT:
            begin
                idx_reg <= pos_reg;
            end
            OP_RM_WRITE:
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            OP_IN_INIT:
            begin
                idx_reg <= count_reg;
            end
            OP_IN_WRITE:
            begin
                idx_reg <= idx_reg - CW'(1);
            end
            OP_FINISH:
            begin
                res_b_reg   <= fin_b_reg;
                res_l_reg   <= fin_l_reg;
                res_st_reg  <= fin_st_reg;
                res_hit_reg <= fin_hit_reg;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // status to the controller
    always_comb
    begin
        stat.pre_ok   = pre_st_reg == ST_OK;
        stat.at_end   = idx_reg == count_reg;
        stat.stop     = ((cmd_reg == CMD_ALLOC) && fit) || ((cmd_reg == CMD_FREE) && m_free);
        stat.act_wr   = act_wr_reg;
        stat.act_rm   = act_rm_reg;
        stat.act_in   = act_in_reg;
        stat.rm_more  = (idx_reg + CW'(1)) < count_reg;
        stat.in_more  = idx_reg > ins_pos_reg;
        stat.out_free = !res_valid_reg || rsp.ready;
    end

    // response transaction
    assign rsp.valid         = res_valid_reg;
    assign rsp.result_begin  = FIELD_W'(res_b_reg);
    assign rsp.result_length = FIELD_W'(res_l_reg);
    assign rsp.status        = res_st_reg;
    assign rsp.hit           = res_hit_reg;

endmodule
